// File: sv/aisne_pkg.sv
// ============================================================================
// aisne_pkg
// Shared types and constants of the AIVDM sentence encoder: character codes,
// sentence layout positions, sequencer states and inter-module structs.
// ============================================================================
package aisne_pkg;

    // Results per input byte before the rest waits for the next byte
    localparam int           RESULT_CAP = 20;
    localparam logic [4:0]   LAST_SLOT  = 5'(RESULT_CAP - 1);

    // ASCII codes used in the sentence text
    localparam logic [6:0]   CH_A       = 7'd65;
    localparam logic [6:0]   CH_I       = 7'd73;
    localparam logic [6:0]   CH_V       = 7'd86;
    localparam logic [6:0]   CH_D       = 7'd68;
    localparam logic [6:0]   CH_M       = 7'd77;
    localparam logic [6:0]   CH_COMMA   = 7'd44;
    localparam logic [6:0]   CH_STAR    = 7'd42;
    localparam logic [6:0]   CH_ZERO    = 7'd48;
    localparam logic [6:0]   CH_HEX_AF  = 7'd55;
    localparam logic [3:0]   HEX_TEN    = 4'd10;

    // Six-bit armoring
    localparam logic [5:0]   ARMOR_SPLIT = 6'd40;
    localparam logic [6:0]   ARMOR_LO    = 7'd48;
    localparam logic [6:0]   ARMOR_HI    = 7'd56;

    // Sentence payload limit clamp
    localparam logic [5:0]   LIMIT_MIN  = 6'd24;
    localparam logic [5:0]   LIMIT_MAX  = 6'd61;

    // Sequence id wraps after this value
    localparam logic [3:0]   SEQ_MAX    = 4'd9;

    // Header character positions with variable content
    localparam logic [3:0]   HP_TOTAL   = 4'd6;
    localparam logic [3:0]   HP_NUM     = 4'd8;
    localparam logic [3:0]   HP_SEQ     = 4'd10;
    localparam logic [3:0]   HP_TAG     = 4'd11;
    localparam logic [3:0]   HP_LAST    = 4'd12;

    // Trailer character positions
    localparam logic [3:0]   TP_FILL    = 4'd1;
    localparam logic [3:0]   TP_STAR    = 4'd2;
    localparam logic [3:0]   TP_HI      = 4'd3;
    localparam logic [3:0]   TP_LAST    = 4'd4;

    // Bits per input byte
    localparam logic [3:0]   BYTE_BITS  = 4'd8;

    // Divide by three: floor(x / 3) = (x * 683) >> 11 for x below 2048
    localparam int           DIV3_MUL   = 683;
    localparam int           DIV3_MW    = 10;
    localparam int           DIV3_SHIFT = 11;

    // Configuration register indexes
    localparam logic         CFG_MAX_TYPE = 1'b0;
    localparam logic         CFG_PAYLOAD  = 1'b1;

    // Character sequencer states
    typedef enum logic [2:0] {
        G_IDLE,
        G_CALC,
        G_HDR,
        G_BITS,
        G_GROUP,
        G_END,
        G_TRL
    } t_gen_state;

    // Sentence count unit states
    typedef enum logic [1:0] {
        SD_IDLE,
        SD_MUL,
        SD_LOOP
    } t_sdiv_state;

    // Sentence count unit result
    typedef struct packed {
        logic       done;
        logic [3:0] total;
        logic [2:0] fill;
    } t_sdiv_res;

    // One character handed to the output register
    typedef struct packed {
        logic       valid;
        logic       last;
        logic       sent;
        logic       msg;
        logic [6:0] ch;
    } t_push;

endpackage

// File: sv/aisne_sdiv.sv
// ============================================================================
// aisne_sdiv
// Sentence count unit: derives the six-bit group count and fill bits of a
// message from its byte count, then divides the group count by the payload
// limit with one shared compare/subtract step per cycle.
// ============================================================================
module aisne_sdiv
    import aisne_pkg::*;
#(
    parameter int MAX_BYTES = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_len,
    input  logic [5:0] i_limit,
    output t_sdiv_res  o_res
);

    localparam int XW = $clog2(4 * MAX_BYTES + 3);
    localparam int GW = $clog2((8 * MAX_BYTES + 5) / 6 + 1);
    localparam int PW = XW + DIV3_MW;
    localparam int CW = (GW > 6) ? GW : 6;

    t_sdiv_state       r_st, n_st;
    logic [XW-1:0]     r_x, n_x;
    logic [GW-1:0]     r_rem, n_rem;
    logic [3:0]        r_cnt, n_cnt;
    logic [2:0]        r_fill, n_fill;

    logic [PW-1:0]     w_prod;
    logic [GW-1:0]     w_groups;
    logic [2:0]        w_fill;
    logic              w_fits;

    // Groups = ceil(8 * len / 6) = floor((4 * len + 2) / 3)
    assign w_prod   = PW'(r_x) * PW'(DIV3_MUL);
    assign w_groups = w_prod[DIV3_SHIFT +: GW];
    // Fill bits = 6 * groups - 8 * len, only the low three bits of 6 * groups
    assign w_fill   = 3'({w_groups[1:0], 2'b00} + {1'b0, w_groups[1:0], 1'b0});
    assign w_fits   = (CW'(r_rem) <= CW'(i_limit));

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SD_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_fill <= n_fill;
    end

    // Next state: latch, multiply, then subtract the limit until it fits
    always_comb begin
        n_st   = r_st;
        n_x    = r_x;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_fill = r_fill;
        case (r_st)
            SD_IDLE: begin
                if (i_start) begin
                    n_x  = XW'({i_len, 2'b00} + 10'd2);
                    n_st = SD_MUL;
                end
            end
            SD_MUL: begin
                n_rem  = w_groups;
                n_fill = w_fill;
                n_cnt  = 4'd1;
                n_st   = SD_LOOP;
            end
            SD_LOOP: begin
                if (w_fits) begin
                    n_st = SD_IDLE;
                end else begin
                    n_rem = r_rem - GW'(i_limit);
                    n_cnt = r_cnt + 4'd1;
                end
            end
            default: begin
                n_st = SD_IDLE;
            end
        endcase
    end

    assign o_res.done  = (r_st == SD_LOOP) && w_fits;
    assign o_res.total = r_cnt;
    assign o_res.fill  = r_fill;

endmodule

// File: sv/aisne_ctrl.sv
// ============================================================================
// aisne_ctrl
// Character sequencer: takes message bytes, shifts their bits one per cycle
// into six-bit groups and walks header, payload and trailer characters of
// each sentence, one character per cycle while the output is free, through a
// one-character lookahead that marks the last character of each request.
// ============================================================================
module aisne_ctrl
    import aisne_pkg::*;
#(
    parameter int MAX_BYTES = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic [7:0] i_in_len,
    input  logic [5:0] i_max_type,
    input  logic [5:0] i_payload_chars,
    input  logic       i_out_free,
    output t_push      o_push
);

    // Request control
    logic        r_active, n_active;
    logic        r_have_byte, n_have_byte;
    logic [7:0]  r_in_byte, n_in_byte;
    logic [7:0]  r_in_len, n_in_len;
    logic [4:0]  r_cnt, n_cnt;

    // Lookahead character
    logic        r_pv, n_pv;
    logic [6:0]  r_pc, n_pc;
    logic        r_psent, n_psent;
    logic        r_pmsg, n_pmsg;

    // Sequencer
    t_gen_state  r_gs, n_gs;
    logic [7:0]  r_sh, n_sh;
    logic [3:0]  r_bitj, n_bitj;
    logic [5:0]  r_acc, n_acc;
    logic [2:0]  r_pend, n_pend;
    logic [7:0]  r_byte_index, n_byte_index;
    logic [7:0]  r_msg_len, n_msg_len;
    logic [5:0]  r_limit, n_limit;
    logic        r_drop, n_drop;
    logic [3:0]  r_total, n_total;
    logic [2:0]  r_fill, n_fill;
    logic [3:0]  r_snum, n_snum;
    logic [5:0]  r_chars, n_chars;
    logic [6:0]  r_chk, n_chk;
    logic [3:0]  r_seq, n_seq;
    logic [3:0]  r_k, n_k;
    logic [5:0]  r_grp, n_grp;
    logic        r_hdr_to_grp, n_hdr_to_grp;
    logic        r_pad, n_pad;
    logic        r_trl_last, n_trl_last;

    // Combinational helpers
    logic        w_accept;
    logic        w_can_emit;
    logic        w_gen_fin;
    logic        w_fire;
    logic [6:0]  w_char;
    logic        w_char_sent;
    logic        w_char_msg;
    logic [7:0]  w_len;
    logic [5:0]  w_lim;
    logic [5:0]  w_type;
    logic        w_drop_new;
    logic        w_sdiv_start;
    logic [5:0]  w_new_acc;
    logic [5:0]  w_pad_grp;
    logic        w_msg_done;
    logic [6:0]  w_hdr_char;
    logic [6:0]  w_grp_char;
    logic [6:0]  w_trl_char;
    t_sdiv_res   w_sdiv;

    function automatic logic [6:0] hex_char(input logic [3:0] n);
        return (n < HEX_TEN) ? (CH_ZERO + 7'(n)) : (CH_HEX_AF + 7'(n));
    endfunction

    function automatic logic [6:0] hdr_char(input logic [3:0] k, input logic [3:0] tot,
                                            input logic [3:0] num, input logic [3:0] seq);
        logic       multi;
        logic [6:0] c;
        multi = (tot > 4'd1);
        case (k)
            4'd0:     c = CH_A;
            4'd1:     c = CH_I;
            4'd2:     c = CH_V;
            4'd3:     c = CH_D;
            4'd4:     c = CH_M;
            HP_TOTAL: c = CH_ZERO + 7'(tot);
            HP_NUM:   c = CH_ZERO + 7'(num);
            HP_SEQ:   c = multi ? (CH_ZERO + 7'(seq)) : CH_COMMA;
            HP_TAG:   c = multi ? CH_COMMA : CH_A;
            default:  c = CH_COMMA;
        endcase
        return c;
    endfunction

    // The count unit latches the clamped length of the byte being taken
    aisne_sdiv #(
        .MAX_BYTES (MAX_BYTES)
    ) u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sdiv_start),
        .i_len   (w_len),
        .i_limit (r_limit),
        .o_res   (w_sdiv)
    );

    assign o_in_ready = !r_active;
    assign w_accept   = i_in_valid && !r_active;
    assign w_can_emit = r_active && (!r_pv || i_out_free);
    assign w_gen_fin  = (r_gs == G_IDLE) && !r_have_byte;

    // Message length and limit clamps, type of the first byte
    assign w_len = (r_in_len == 8'd0) ? 8'd1 :
                   ((r_in_len > 8'(MAX_BYTES)) ? 8'(MAX_BYTES) : r_in_len);
    assign w_lim = (i_payload_chars < LIMIT_MIN) ? LIMIT_MIN :
                   ((i_payload_chars > LIMIT_MAX) ? LIMIT_MAX : i_payload_chars);
    assign w_type = {r_in_byte[0], r_in_byte[1], r_in_byte[2],
                     r_in_byte[3], r_in_byte[4], r_in_byte[5]};
    assign w_drop_new = (w_type == 6'd0) || (w_type > i_max_type);

    assign w_new_acc  = {r_acc[4:0], r_sh[0]};
    assign w_pad_grp  = 6'(r_acc << (3'd6 - r_pend));
    assign w_msg_done = ({1'b0, r_byte_index} + 9'd1) >= {1'b0, r_msg_len};

    // Character sources
    assign w_hdr_char = hdr_char(r_k, r_total, r_snum, r_seq);
    assign w_grp_char = (r_grp < ARMOR_SPLIT) ? (7'(r_grp) + ARMOR_LO)
                                              : (7'(r_grp) + ARMOR_HI);
    always_comb begin
        case (r_k)
            TP_FILL: w_trl_char = CH_ZERO + (r_trl_last ? 7'(r_fill) : 7'd0);
            TP_STAR: w_trl_char = CH_STAR;
            TP_HI:   w_trl_char = hex_char({1'b0, r_chk[6:4]});
            TP_LAST: w_trl_char = hex_char(r_chk[3:0]);
            default: w_trl_char = CH_COMMA;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_have_byte  <= 1'b0;
            r_pv         <= 1'b0;
            r_gs         <= G_IDLE;
            r_byte_index <= '0;
            r_drop       <= 1'b0;
            r_seq        <= '0;
            r_acc        <= '0;
            r_pend       <= '0;
            r_chars      <= '0;
            r_cnt        <= '0;
        end else begin
            r_active     <= n_active;
            r_have_byte  <= n_have_byte;
            r_pv         <= n_pv;
            r_gs         <= n_gs;
            r_byte_index <= n_byte_index;
            r_drop       <= n_drop;
            r_seq        <= n_seq;
            r_acc        <= n_acc;
            r_pend       <= n_pend;
            r_chars      <= n_chars;
            r_cnt        <= n_cnt;
        end
        r_in_byte    <= n_in_byte;
        r_in_len     <= n_in_len;
        r_pc         <= n_pc;
        r_psent      <= n_psent;
        r_pmsg       <= n_pmsg;
        r_sh         <= n_sh;
        r_bitj       <= n_bitj;
        r_msg_len    <= n_msg_len;
        r_limit      <= n_limit;
        r_total      <= n_total;
        r_fill       <= n_fill;
        r_snum       <= n_snum;
        r_chk        <= n_chk;
        r_k          <= n_k;
        r_grp        <= n_grp;
        r_hdr_to_grp <= n_hdr_to_grp;
        r_pad        <= n_pad;
        r_trl_last   <= n_trl_last;
    end

    // Next state of the sequencer and the lookahead
    always_comb begin
        n_active     = r_active;
        n_have_byte  = r_have_byte;
        n_in_byte    = r_in_byte;
        n_in_len     = r_in_len;
        n_cnt        = r_cnt;
        n_pv         = r_pv;
        n_pc         = r_pc;
        n_psent      = r_psent;
        n_pmsg       = r_pmsg;
        n_gs         = r_gs;
        n_sh         = r_sh;
        n_bitj       = r_bitj;
        n_acc        = r_acc;
        n_pend       = r_pend;
        n_byte_index = r_byte_index;
        n_msg_len    = r_msg_len;
        n_limit      = r_limit;
        n_drop       = r_drop;
        n_total      = r_total;
        n_fill       = r_fill;
        n_snum       = r_snum;
        n_chars      = r_chars;
        n_chk        = r_chk;
        n_seq        = r_seq;
        n_k          = r_k;
        n_grp        = r_grp;
        n_hdr_to_grp = r_hdr_to_grp;
        n_pad        = r_pad;
        n_trl_last   = r_trl_last;
        w_fire       = 1'b0;
        w_char       = '0;
        w_char_sent  = 1'b0;
        w_char_msg   = 1'b0;
        w_sdiv_start = 1'b0;
        o_push       = '0;

        case (r_gs)
            // Take the buffered byte; the first byte of a message latches its setup
            G_IDLE: begin
                if (r_active && r_have_byte) begin
                    n_have_byte = 1'b0;
                    n_sh        = r_in_byte;
                    n_bitj      = '0;
                    if (r_byte_index == 8'd0) begin
                        n_msg_len = w_len;
                        n_limit   = w_lim;
                        n_drop    = w_drop_new;
                        if (w_drop_new) begin
                            n_gs = G_END;
                        end else begin
                            w_sdiv_start = 1'b1;
                            n_gs         = G_CALC;
                        end
                    end else begin
                        n_gs = r_drop ? G_END : G_BITS;
                    end
                end
            end
            // Wait for the sentence count, then open the first sentence
            G_CALC: begin
                if (w_sdiv.done) begin
                    n_total      = w_sdiv.total;
                    n_fill       = w_sdiv.fill;
                    n_snum       = 4'd1;
                    n_chars      = '0;
                    n_acc        = '0;
                    n_pend       = '0;
                    n_k          = '0;
                    n_hdr_to_grp = 1'b0;
                    n_gs         = G_HDR;
                end
            end
            G_HDR: begin
                if (w_can_emit) begin
                    w_fire = 1'b1;
                    w_char = w_hdr_char;
                    n_chk  = (r_k == 4'd0) ? w_hdr_char : (r_chk ^ w_hdr_char);
                    if (r_k == HP_LAST) begin
                        n_k  = '0;
                        n_gs = r_hdr_to_grp ? G_GROUP : G_BITS;
                    end else begin
                        n_k = r_k + 4'd1;
                    end
                end
            end
            // Shift one bit in; a full group goes out as a character
            G_BITS: begin
                if (r_active) begin
                    n_sh   = {1'b0, r_sh[7:1]};
                    n_bitj = r_bitj + 4'd1;
                    if (r_pend == 3'd5) begin
                        n_grp  = w_new_acc;
                        n_acc  = '0;
                        n_pend = '0;
                        n_pad  = 1'b0;
                        n_gs   = G_GROUP;
                    end else begin
                        n_acc  = w_new_acc;
                        n_pend = r_pend + 3'd1;
                        if (r_bitj == BYTE_BITS - 4'd1) begin
                            n_gs = G_END;
                        end
                    end
                end
            end
            // Close the sentence first when it is full
            G_GROUP: begin
                if (r_chars >= r_limit) begin
                    if (r_active) begin
                        n_k        = '0;
                        n_trl_last = 1'b0;
                        n_gs       = G_TRL;
                    end
                end else if (w_can_emit) begin
                    w_fire  = 1'b1;
                    w_char  = w_grp_char;
                    n_chk   = r_chk ^ w_grp_char;
                    n_chars = r_chars + 6'd1;
                    if (r_pad) begin
                        n_k        = '0;
                        n_trl_last = 1'b1;
                        n_gs       = G_TRL;
                    end else if (r_bitj == BYTE_BITS) begin
                        n_gs = G_END;
                    end else begin
                        n_gs = G_BITS;
                    end
                end
            end
            // End of byte: pad and close on the last byte of a message
            G_END: begin
                if (r_active) begin
                    if (w_msg_done) begin
                        if (r_drop) begin
                            n_byte_index = '0;
                            n_drop       = 1'b0;
                            n_acc        = '0;
                            n_pend       = '0;
                            n_chars      = '0;
                            n_gs         = G_IDLE;
                        end else if (r_pend != 3'd0) begin
                            n_grp  = w_pad_grp;
                            n_pad  = 1'b1;
                            n_gs   = G_GROUP;
                        end else begin
                            n_k        = '0;
                            n_trl_last = 1'b1;
                            n_gs       = G_TRL;
                        end
                    end else begin
                        n_byte_index = r_byte_index + 8'd1;
                        n_gs         = G_IDLE;
                    end
                end
            end
            G_TRL: begin
                if (w_can_emit) begin
                    w_fire = 1'b1;
                    w_char = w_trl_char;
                    if (r_k < TP_STAR) begin
                        n_chk = r_chk ^ w_trl_char;
                    end
                    if (r_k == TP_LAST) begin
                        w_char_sent = 1'b1;
                        w_char_msg  = r_trl_last;
                        n_k         = '0;
                        n_chars     = '0;
                        if (r_trl_last) begin
                            n_seq        = (r_seq >= SEQ_MAX) ? 4'd0 : (r_seq + 4'd1);
                            n_byte_index = '0;
                            n_drop       = 1'b0;
                            n_acc        = '0;
                            n_pend       = '0;
                            n_gs         = G_IDLE;
                        end else begin
                            n_snum       = r_snum + 4'd1;
                            n_hdr_to_grp = 1'b1;
                            n_gs         = G_HDR;
                        end
                    end else begin
                        n_k = r_k + 4'd1;
                    end
                end
            end
            default: begin
                n_gs = G_IDLE;
            end
        endcase

        // Advance the lookahead; the character after the cap waits for the next request
        if (w_fire) begin
            if (r_pv) begin
                o_push.valid = 1'b1;
                o_push.last  = (r_cnt == LAST_SLOT);
                o_push.sent  = r_psent;
                o_push.msg   = r_pmsg;
                o_push.ch    = r_pc;
                n_cnt        = r_cnt + 5'd1;
                if (r_cnt == LAST_SLOT) begin
                    n_active = 1'b0;
                end
            end
            n_pv    = 1'b1;
            n_pc    = w_char;
            n_psent = w_char_sent;
            n_pmsg  = w_char_msg;
        end else if (r_active && w_gen_fin) begin
            if (r_pv) begin
                if (i_out_free) begin
                    o_push.valid = 1'b1;
                    o_push.last  = 1'b1;
                    o_push.sent  = r_psent;
                    o_push.msg   = r_pmsg;
                    o_push.ch    = r_pc;
                    n_cnt        = r_cnt + 5'd1;
                    n_pv         = 1'b0;
                    n_active     = 1'b0;
                end
            end else begin
                n_active = 1'b0;
            end
        end

        // Accept a new byte
        if (w_accept) begin
            n_active    = 1'b1;
            n_have_byte = 1'b1;
            n_in_byte   = i_in_byte;
            n_in_len    = i_in_len;
            n_cnt       = '0;
        end
    end

    // Never push into a busy output register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> i_out_free)
        else $error("character pushed while output register busy");

    // Never more than the cap of characters per request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> (r_cnt <= LAST_SLOT))
        else $error("too many characters for one request");

    // The last character of a request ends the request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && o_push.last) |=> !r_active)
        else $error("request still active after its last character");

    // A buffered byte belongs to an active request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_byte |-> r_active)
        else $error("byte buffered outside a request");

endmodule

// File: sv/ais_nmea_sentence_encoder.sv
// ============================================================================
// ais_nmea_sentence_encoder
// AIVDM sentence encoder top level: configuration registers, sequencer and
// the registered output stage of the character stream.
// ============================================================================
// Takes an AIS message one byte per request (with its byte count on every
// byte) and returns the ASCII text of the AIVDM sentences carrying it, one
// character per output transfer; messages whose type is not in
// 1..max_type produce nothing. Each request ends with tlast on its final
// character, and returns at most 20 characters; the tail of a longer burst
// is returned at the head of the next request. One request is worked at a
// time: s_axis_tready is low from acceptance until its last character is in
// the output register. The sequencer shifts the byte one bit per cycle and
// emits one character per cycle while the output is not stalled; on the
// first byte of a message it first derives the sentence count (one
// multiply, then one compare and subtract of the payload limit per sentence
// of the message).
module ais_nmea_sentence_encoder
    import aisne_pkg::*;
#(
    parameter int MAX_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] message_bytes
    // Sentence characters
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic [1:0]  m_axis_tuser,   // [0] sentence_end, [1] message_end
    output logic        m_axis_tlast,   // run_last
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [5:0]  i_cfg_wdata
);

    logic [5:0] r_max_type, n_max_type;
    logic [5:0] r_payload, n_payload;
    logic       r_m_valid, n_m_valid;
    logic [6:0] r_m_char, n_m_char;
    logic       r_m_sent, n_m_sent;
    logic       r_m_msg, n_m_msg;
    logic       r_m_last, n_m_last;

    logic       w_out_free;
    t_push      w_push;

    aisne_ctrl #(
        .MAX_BYTES (MAX_BYTES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .o_in_ready      (s_axis_tready),
        .i_in_byte       (s_axis_tdata[7:0]),
        .i_in_len        (s_axis_tdata[15:8]),
        .i_max_type      (r_max_type),
        .i_payload_chars (r_payload),
        .i_out_free      (w_out_free),
        .o_push          (w_push)
    );

    assign w_out_free = !r_m_valid || m_axis_tready;

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_type <= 6'd4;
            r_payload  <= 6'd61;
            r_m_valid  <= 1'b0;
        end else begin
            r_max_type <= n_max_type;
            r_payload  <= n_payload;
            r_m_valid  <= n_m_valid;
        end
        r_m_char <= n_m_char;
        r_m_sent <= n_m_sent;
        r_m_msg  <= n_m_msg;
        r_m_last <= n_m_last;
    end

    // Write configuration and load or drain the output register
    always_comb begin
        n_max_type = r_max_type;
        n_payload  = r_payload;
        n_m_valid  = r_m_valid;
        n_m_char   = r_m_char;
        n_m_sent   = r_m_sent;
        n_m_msg    = r_m_msg;
        n_m_last   = r_m_last;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAX_TYPE: n_max_type = i_cfg_wdata;
                CFG_PAYLOAD:  n_payload  = i_cfg_wdata;
                default: ;
            endcase
        end
        if (w_push.valid) begin
            n_m_valid = 1'b1;
            n_m_char  = w_push.ch;
            n_m_sent  = w_push.sent;
            n_m_msg   = w_push.msg;
            n_m_last  = w_push.last;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_char};
    assign m_axis_tuser  = {r_m_msg, r_m_sent};
    assign m_axis_tlast  = r_m_last;

endmodule
